// File: sv/tcop_pkg.sv
// shared types and constants for the telnet com-port option parser
// used by the front, queue, back and top-level modules
package tcop_pkg;

  localparam int SUB_CAPACITY = 32;
  localparam int SUB_KEPT     = 5;
  localparam int SUB_CNT_W    = $clog2(SUB_CAPACITY + 1);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);

  localparam logic [7:0] B_IAC    = 8'd255;
  localparam logic [7:0] B_DONT   = 8'd254;
  localparam logic [7:0] B_DO     = 8'd253;
  localparam logic [7:0] B_WONT   = 8'd252;
  localparam logic [7:0] B_WILL   = 8'd251;
  localparam logic [7:0] B_SB     = 8'd250;
  localparam logic [7:0] B_SE     = 8'd240;
  localparam logic [7:0] OPT_COM  = 8'd44;
  localparam logic [7:0] RESP_ADD = 8'd100;

  localparam logic [7:0] CMD_BAUD     = 8'd1;
  localparam logic [7:0] CMD_DATASIZE = 8'd2;
  localparam logic [7:0] CMD_PARITY   = 8'd3;
  localparam logic [7:0] CMD_STOPSIZE = 8'd4;
  localparam logic [7:0] CMD_CONTROL  = 8'd5;
  localparam logic [7:0] CMD_PURGE    = 8'd12;

  localparam logic [7:0] CTL_DTR_ON  = 8'd8;
  localparam logic [7:0] CTL_DTR_OFF = 8'd9;
  localparam logic [7:0] CTL_RTS_ON  = 8'd11;
  localparam logic [7:0] CTL_RTS_OFF = 8'd12;

  localparam logic [7:0] DEF_DATASIZE = 8'd8;
  localparam logic [7:0] DEF_PARITY   = 8'd0;
  localparam logic [7:0] DEF_STOPSIZE = 8'd1;
  localparam logic [7:0] DEF_PURGE    = 8'd0;

  typedef enum logic [1:0] {
    KIND_SERIAL = 2'd0,
    KIND_NET    = 2'd1,
    KIND_LINE   = 2'd2,
    KIND_CTL    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PS_DATA, PS_IAC, PS_WILL, PS_WONT, PS_DO, PS_DONT, PS_SB, PS_SBDATA, PS_SBIAC
  } pstate_t;

  typedef enum logic [1:0] {
    JOB_DATA, JOB_CMD3, JOB_BAUD, JOB_SUB1
  } jkind_t;

  typedef struct packed {
    jkind_t      jkind;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [31:0] baud;
    logic        ev;
    logic        dtr;
    logic        rts;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] baud_rate;
    logic        dtr_out;
    logic        rts_out;
    logic        last;
  } out_t;

endpackage

// File: sv/tcop_front.sv
// front part: telnet parse state machine, subnegotiation store and line levels
// turns each accepted byte into at most one job; uses tcop_pkg
module tcop_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  tcop_pkg::in_t  in_item,
  output logic           push,
  output tcop_pkg::job_t job
);

  tcop_pkg::pstate_t state_r, state_nxt;
  logic [7:0] sub_opt_r, sub_opt_nxt;
  logic [tcop_pkg::SUB_CNT_W-1:0] cnt_r, cnt_nxt;
  logic dtr_r, dtr_nxt, rts_r, rts_nxt;
  logic [7:0] sb_r [tcop_pkg::SUB_KEPT];
  logic       wr_en;
  logic [2:0] wr_idx;
  logic       do_collect;
  logic [7:0] col_byte;
  logic [7:0] b;
  logic [7:0] cmd;
  logic       has_param;
  logic       has_baud;
  logic [31:0] baud;

  assign b         = in_item.in_byte;
  assign cmd       = sb_r[0];
  assign has_param = cnt_r >= tcop_pkg::SUB_CNT_W'(2);
  assign has_baud  = cnt_r >= tcop_pkg::SUB_CNT_W'(5);
  assign baud      = {sb_r[1], sb_r[2], sb_r[3], sb_r[4]};
  assign wr_idx    = cnt_r[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcop_pkg::PS_DATA;
      sub_opt_r <= '0;
      cnt_r     <= '0;
      dtr_r     <= 1'b1;
      rts_r     <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      sub_opt_r <= sub_opt_nxt;
      cnt_r     <= cnt_nxt;
      dtr_r     <= dtr_nxt;
      rts_r     <= rts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sb_r[wr_idx] <= col_byte;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sub_opt_nxt = sub_opt_r;
    cnt_nxt     = cnt_r;
    dtr_nxt     = dtr_r;
    rts_nxt     = rts_r;
    push        = 1'b0;
    job         = '0;
    do_collect  = 1'b0;
    col_byte    = b;
    wr_en       = 1'b0;
    if (accept) begin
      if (in_item.req_type) begin
        state_nxt   = tcop_pkg::PS_DATA;
        dtr_nxt     = 1'b1;
        rts_nxt     = 1'b1;
        sub_opt_nxt = '0;
        cnt_nxt     = '0;
        push        = 1'b1;
        job.jkind   = tcop_pkg::JOB_CMD3;
        job.b0      = tcop_pkg::B_WILL;
        job.b1      = tcop_pkg::OPT_COM;
      end else begin
        unique case (state_r)
          tcop_pkg::PS_DATA: begin
            if (b == tcop_pkg::B_IAC) begin
              state_nxt = tcop_pkg::PS_IAC;
            end else begin
              push      = 1'b1;
              job.jkind = tcop_pkg::JOB_DATA;
              job.b0    = b;
            end
          end
          tcop_pkg::PS_IAC: begin
            state_nxt = tcop_pkg::PS_DATA;
            if (b == tcop_pkg::B_IAC) begin
              push      = 1'b1;
              job.jkind = tcop_pkg::JOB_DATA;
              job.b0    = b;
            end else if (b == tcop_pkg::B_WILL) begin
              state_nxt = tcop_pkg::PS_WILL;
            end else if (b == tcop_pkg::B_WONT) begin
              state_nxt = tcop_pkg::PS_WONT;
            end else if (b == tcop_pkg::B_DO) begin
              state_nxt = tcop_pkg::PS_DO;
            end else if (b == tcop_pkg::B_DONT) begin
              state_nxt = tcop_pkg::PS_DONT;
            end else if (b == tcop_pkg::B_SB) begin
              state_nxt = tcop_pkg::PS_SB;
            end
          end
          tcop_pkg::PS_WILL, tcop_pkg::PS_WONT, tcop_pkg::PS_DO, tcop_pkg::PS_DONT: begin
            state_nxt = tcop_pkg::PS_DATA;
            push      = 1'b1;
            job.jkind = tcop_pkg::JOB_CMD3;
            job.b1    = b;
            if (state_r == tcop_pkg::PS_WILL) begin
              job.b0 = (b == tcop_pkg::OPT_COM) ? tcop_pkg::B_DO : tcop_pkg::B_DONT;
            end else if (state_r == tcop_pkg::PS_DO) begin
              job.b0 = (b == tcop_pkg::OPT_COM) ? tcop_pkg::B_WILL : tcop_pkg::B_WONT;
            end else if (state_r == tcop_pkg::PS_WONT) begin
              job.b0 = tcop_pkg::B_DONT;
            end else begin
              job.b0 = tcop_pkg::B_WONT;
            end
          end
          tcop_pkg::PS_SB: begin
            sub_opt_nxt = b;
            cnt_nxt     = '0;
            state_nxt   = tcop_pkg::PS_SBDATA;
          end
          tcop_pkg::PS_SBDATA: begin
            if (b == tcop_pkg::B_IAC) begin
              state_nxt = tcop_pkg::PS_SBIAC;
            end else begin
              do_collect = 1'b1;
            end
          end
          tcop_pkg::PS_SBIAC: begin
            if (b == tcop_pkg::B_SE) begin
              state_nxt = tcop_pkg::PS_DATA;
              if (sub_opt_r == tcop_pkg::OPT_COM && cnt_r != '0) begin
                job.jkind = tcop_pkg::JOB_SUB1;
                job.b0    = cmd;
                unique case (cmd)
                  tcop_pkg::CMD_BAUD: begin
                    push      = has_baud;
                    job.jkind = tcop_pkg::JOB_BAUD;
                    job.baud  = baud;
                    job.ev    = baud != '0;
                  end
                  tcop_pkg::CMD_DATASIZE: begin
                    push   = 1'b1;
                    job.b1 = has_param ? sb_r[1] : tcop_pkg::DEF_DATASIZE;
                  end
                  tcop_pkg::CMD_PARITY: begin
                    push   = 1'b1;
                    job.b1 = has_param ? sb_r[1] : tcop_pkg::DEF_PARITY;
                  end
                  tcop_pkg::CMD_STOPSIZE: begin
                    push   = 1'b1;
                    job.b1 = has_param ? sb_r[1] : tcop_pkg::DEF_STOPSIZE;
                  end
                  tcop_pkg::CMD_PURGE: begin
                    push   = 1'b1;
                    job.b1 = has_param ? sb_r[1] : tcop_pkg::DEF_PURGE;
                  end
                  tcop_pkg::CMD_CONTROL: begin
                    if (has_param) begin
                      push   = 1'b1;
                      job.b1 = sb_r[1];
                      job.ev = 1'b1;
                      if (sb_r[1] == tcop_pkg::CTL_DTR_ON) begin
                        dtr_nxt = 1'b1;
                      end else if (sb_r[1] == tcop_pkg::CTL_DTR_OFF) begin
                        dtr_nxt = 1'b0;
                      end else if (sb_r[1] == tcop_pkg::CTL_RTS_ON) begin
                        rts_nxt = 1'b1;
                      end else if (sb_r[1] == tcop_pkg::CTL_RTS_OFF) begin
                        rts_nxt = 1'b0;
                      end
                      job.dtr = dtr_nxt;
                      job.rts = rts_nxt;
                    end
                  end
                  default: begin
                    push = 1'b0;
                  end
                endcase
              end
            end else if (b == tcop_pkg::B_IAC) begin
              do_collect = 1'b1;
              state_nxt  = tcop_pkg::PS_SBDATA;
            end else begin
              state_nxt = tcop_pkg::PS_DATA;
            end
          end
          default: begin
            state_nxt = tcop_pkg::PS_DATA;
          end
        endcase
      end
    end
    if (do_collect && cnt_r < tcop_pkg::SUB_CNT_W'(tcop_pkg::SUB_CAPACITY)) begin
      wr_en   = cnt_r < tcop_pkg::SUB_CNT_W'(tcop_pkg::SUB_KEPT);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

endmodule

// File: sv/tcop_queue.sv
// short job queue between the parser front and the reply back
// register-based fifo of tcop_pkg::job_t entries
module tcop_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tcop_pkg::job_t     push_job,
  input  logic               pop,
  output tcop_pkg::job_t     head,
  output tcop_pkg::q_stat_t  stat
);

  tcop_pkg::job_t mem_r [tcop_pkg::QDEPTH];
  logic [tcop_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [tcop_pkg::QPTR_W:0]   cnt_r;

  assign head       = mem_r[rd_r];
  assign stat.full  = cnt_r == (tcop_pkg::QPTR_W + 1)'(tcop_pkg::QDEPTH);
  assign stat.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (tcop_pkg::QPTR_W + 1)'(push) - (tcop_pkg::QPTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
    else $error("queue read while empty");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> wr_r == rd_r)
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: sv/tcop_back.sv
// back part: expands each queued job into result items, one per cycle while out_stall is low
// drives the registered result channel; uses tcop_pkg
module tcop_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tcop_pkg::job_t     hj,
  input  tcop_pkg::q_stat_t  qs,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tcop_pkg::out_t     out_data
);

  logic [3:0] idx_r;
  logic [3:0] p;
  logic [3:0] len;
  logic       load;
  logic       out_valid_r;
  tcop_pkg::out_t out_data_r, res;

  assign load      = !out_valid_r || !out_stall;
  assign pop       = load && !qs.empty && res.last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign p         = idx_r - 4'(hj.ev);

  always_comb begin
    res = '0;
    len = 4'd1;
    if (hj.jkind == tcop_pkg::JOB_DATA) begin
      res.kind     = tcop_pkg::KIND_SERIAL;
      res.out_byte = hj.b0;
    end else if (hj.ev && idx_r == '0) begin
      if (hj.jkind == tcop_pkg::JOB_BAUD) begin
        res.kind      = tcop_pkg::KIND_LINE;
        res.baud_rate = hj.baud;
      end else begin
        res.kind    = tcop_pkg::KIND_CTL;
        res.dtr_out = hj.dtr;
        res.rts_out = hj.rts;
      end
    end else begin
      res.kind = tcop_pkg::KIND_NET;
      if (hj.jkind == tcop_pkg::JOB_CMD3) begin
        case (p)
          4'd0:    res.out_byte = tcop_pkg::B_IAC;
          4'd1:    res.out_byte = hj.b0;
          default: res.out_byte = hj.b1;
        endcase
      end else begin
        case (p)
          4'd0:    res.out_byte = tcop_pkg::B_IAC;
          4'd1:    res.out_byte = tcop_pkg::B_SB;
          4'd2:    res.out_byte = tcop_pkg::OPT_COM;
          4'd3:    res.out_byte = hj.b0 + tcop_pkg::RESP_ADD;
          default: res.out_byte = '0;
        endcase
        if (hj.jkind == tcop_pkg::JOB_BAUD) begin
          case (p)
            4'd4: res.out_byte = hj.baud[31:24];
            4'd5: res.out_byte = hj.baud[23:16];
            4'd6: res.out_byte = hj.baud[15:8];
            4'd7: res.out_byte = hj.baud[7:0];
            4'd8: res.out_byte = tcop_pkg::B_IAC;
            4'd9: res.out_byte = tcop_pkg::B_SE;
            default: ;
          endcase
        end else begin
          case (p)
            4'd4: res.out_byte = hj.b1;
            4'd5: res.out_byte = tcop_pkg::B_IAC;
            4'd6: res.out_byte = tcop_pkg::B_SE;
            default: ;
          endcase
        end
      end
    end
    case (hj.jkind)
      tcop_pkg::JOB_DATA: len = 4'd1;
      tcop_pkg::JOB_CMD3: len = 4'd3;
      tcop_pkg::JOB_BAUD: len = 4'd10 + 4'(hj.ev);
      default:            len = 4'd7 + 4'(hj.ev);
    endcase
    res.last = idx_r == len - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= !qs.empty;
      if (!qs.empty) begin
        idx_r <= res.last ? 4'd0 : idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_mid_job_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0 |-> !qs.empty)
    else $error("job index advanced with no job queued");
  a_pop_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && out_data_r.last)
    else $error("job retired without a final result item");
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !qs.empty |-> idx_r < len)
    else $error("job index beyond job length");
`endif

endmodule

// File: sv/telnet_comport_option_parser_unit.sv
// top level of the telnet com-port option parser
// connects tcop_front, tcop_queue and tcop_back; types from tcop_pkg
//
// The parser takes one received network byte (or a new-connection request) per cycle
// while in_stall is low; the parse state machine in the front settles each byte in the
// cycle it is accepted. Each byte turns into at most one job in a four-entry queue, and
// the back expands a job into result items at one per cycle while out_stall is low: a
// data byte gives one item, an option reply three, a com-port reply seven to eleven. So
// plain bytes run at one item per cycle while out_stall is low, and a reply burst holds
// the back until its last item is out; in_stall rises only when the queue is full.
module telnet_comport_option_parser_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tcop_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tcop_pkg::out_t out_data
);

  logic              accept;
  logic              push;
  logic              pop;
  tcop_pkg::job_t    job;
  tcop_pkg::job_t    head;
  tcop_pkg::q_stat_t qs;

  assign in_stall = qs.full;
  assign accept   = in_valid && !in_stall;

  tcop_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .push    (push),
    .job     (job)
  );

  tcop_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (qs)
  );

  tcop_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hj        (head),
    .qs        (qs),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: bench/tb.sv
// testbench for telnet_comport_option_parser_unit: directed and random telnet byte streams,
// checked result by result against a parser model kept inside the bench
// depends on tcop_pkg and the rtl of the parser unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  tcop_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  tcop_pkg::out_t out_data;

  tcop_pkg::in_t  stim_q[$];
  tcop_pkg::out_t due_q[$];
  tcop_pkg::out_t burst[$];

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int n_items      = 0;
  int n_errors     = 0;
  int idle_cycles  = 0;

  tcop_pkg::pstate_t ps      = tcop_pkg::PS_DATA;
  logic [7:0]        sub_opt = 8'd0;
  logic [7:0]        sub_buf [tcop_pkg::SUB_KEPT] = '{default: 8'd0};
  int                sub_cnt = 0;
  logic              dtr_lvl = 1'b1;
  logic              rts_lvl = 1'b1;

  always #5 clk = ~clk;

  telnet_comport_option_parser_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  task automatic put(tcop_pkg::kind_t k, logic [7:0] b, logic [31:0] baud, logic d, logic r);
    tcop_pkg::out_t o;
    o.kind      = k;
    o.out_byte  = b;
    o.baud_rate = baud;
    o.dtr_out   = d;
    o.rts_out   = r;
    o.last      = 1'b0;
    burst.push_back(o);
  endtask

  task automatic put_net(logic [7:0] b);
    put(tcop_pkg::KIND_NET, b, 32'd0, 1'b0, 1'b0);
  endtask

  task automatic put_cmd3(logic [7:0] c, logic [7:0] opt);
    put_net(tcop_pkg::B_IAC);
    put_net(c);
    put_net(opt);
  endtask

  task automatic put_sub_reply(logic [7:0] cmd, logic [7:0] pay [4], int n);
    put_net(tcop_pkg::B_IAC);
    put_net(tcop_pkg::B_SB);
    put_net(tcop_pkg::OPT_COM);
    put_net(cmd + tcop_pkg::RESP_ADD);
    for (int i = 0; i < n; i++) put_net(pay[i]);
    put_net(tcop_pkg::B_IAC);
    put_net(tcop_pkg::B_SE);
  endtask

  task automatic store_sub(logic [7:0] b);
    if (sub_cnt < tcop_pkg::SUB_CAPACITY) begin
      if (sub_cnt < tcop_pkg::SUB_KEPT) sub_buf[sub_cnt] = b;
      sub_cnt++;
    end
  endtask

  task automatic finish_sub();
    logic [7:0]  cmd;
    logic [7:0]  pay [4];
    logic [31:0] baud;
    int          plen;
    if (sub_opt != tcop_pkg::OPT_COM || sub_cnt < 1) return;
    cmd  = sub_buf[0];
    plen = sub_cnt - 1;
    pay  = '{default: 8'd0};
    case (cmd)
      tcop_pkg::CMD_BAUD: begin
        if (plen < 4) return;
        baud = {sub_buf[1], sub_buf[2], sub_buf[3], sub_buf[4]};
        if (baud != 32'd0) put(tcop_pkg::KIND_LINE, 8'd0, baud, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) pay[i] = sub_buf[i + 1];
        put_sub_reply(cmd, pay, 4);
      end
      tcop_pkg::CMD_DATASIZE: begin
        pay[0] = (plen >= 1) ? sub_buf[1] : tcop_pkg::DEF_DATASIZE;
        put_sub_reply(cmd, pay, 1);
      end
      tcop_pkg::CMD_PARITY: begin
        pay[0] = (plen >= 1) ? sub_buf[1] : tcop_pkg::DEF_PARITY;
        put_sub_reply(cmd, pay, 1);
      end
      tcop_pkg::CMD_STOPSIZE: begin
        pay[0] = (plen >= 1) ? sub_buf[1] : tcop_pkg::DEF_STOPSIZE;
        put_sub_reply(cmd, pay, 1);
      end
      tcop_pkg::CMD_CONTROL: begin
        if (plen < 1) return;
        pay[0] = sub_buf[1];
        case (pay[0])
          tcop_pkg::CTL_DTR_ON:  dtr_lvl = 1'b1;
          tcop_pkg::CTL_DTR_OFF: dtr_lvl = 1'b0;
          tcop_pkg::CTL_RTS_ON:  rts_lvl = 1'b1;
          tcop_pkg::CTL_RTS_OFF: rts_lvl = 1'b0;
          default: ;
        endcase
        put(tcop_pkg::KIND_CTL, 8'd0, 32'd0, dtr_lvl, rts_lvl);
        put_sub_reply(cmd, pay, 1);
      end
      tcop_pkg::CMD_PURGE: begin
        pay[0] = (plen >= 1) ? sub_buf[1] : tcop_pkg::DEF_PURGE;
        put_sub_reply(cmd, pay, 1);
      end
      default: ;
    endcase
  endtask

  task automatic parse_item(tcop_pkg::in_t it);
    logic [7:0] b;
    b = it.in_byte;
    burst.delete();
    if (it.req_type) begin
      ps      = tcop_pkg::PS_DATA;
      dtr_lvl = 1'b1;
      rts_lvl = 1'b1;
      sub_opt = 8'd0;
      sub_cnt = 0;
      put_cmd3(tcop_pkg::B_WILL, tcop_pkg::OPT_COM);
    end else begin
      case (ps)
        tcop_pkg::PS_DATA: begin
          if (b == tcop_pkg::B_IAC) ps = tcop_pkg::PS_IAC;
          else put(tcop_pkg::KIND_SERIAL, b, 32'd0, 1'b0, 1'b0);
        end
        tcop_pkg::PS_IAC: begin
          ps = tcop_pkg::PS_DATA;
          if (b == tcop_pkg::B_IAC) put(tcop_pkg::KIND_SERIAL, b, 32'd0, 1'b0, 1'b0);
          else if (b == tcop_pkg::B_WILL) ps = tcop_pkg::PS_WILL;
          else if (b == tcop_pkg::B_WONT) ps = tcop_pkg::PS_WONT;
          else if (b == tcop_pkg::B_DO) ps = tcop_pkg::PS_DO;
          else if (b == tcop_pkg::B_DONT) ps = tcop_pkg::PS_DONT;
          else if (b == tcop_pkg::B_SB) ps = tcop_pkg::PS_SB;
        end
        tcop_pkg::PS_WILL: begin
          if (b == tcop_pkg::OPT_COM) put_cmd3(tcop_pkg::B_DO, tcop_pkg::OPT_COM);
          else put_cmd3(tcop_pkg::B_DONT, b);
          ps = tcop_pkg::PS_DATA;
        end
        tcop_pkg::PS_WONT: begin
          put_cmd3(tcop_pkg::B_DONT, b);
          ps = tcop_pkg::PS_DATA;
        end
        tcop_pkg::PS_DO: begin
          if (b == tcop_pkg::OPT_COM) put_cmd3(tcop_pkg::B_WILL, tcop_pkg::OPT_COM);
          else put_cmd3(tcop_pkg::B_WONT, b);
          ps = tcop_pkg::PS_DATA;
        end
        tcop_pkg::PS_DONT: begin
          put_cmd3(tcop_pkg::B_WONT, b);
          ps = tcop_pkg::PS_DATA;
        end
        tcop_pkg::PS_SB: begin
          sub_opt = b;
          sub_cnt = 0;
          ps      = tcop_pkg::PS_SBDATA;
        end
        tcop_pkg::PS_SBDATA: begin
          if (b == tcop_pkg::B_IAC) ps = tcop_pkg::PS_SBIAC;
          else store_sub(b);
        end
        tcop_pkg::PS_SBIAC: begin
          if (b == tcop_pkg::B_SE) begin
            finish_sub();
            ps = tcop_pkg::PS_DATA;
          end else if (b == tcop_pkg::B_IAC) begin
            store_sub(tcop_pkg::B_IAC);
            ps = tcop_pkg::PS_SBDATA;
          end else begin
            ps = tcop_pkg::PS_DATA;
          end
        end
        default: ps = tcop_pkg::PS_DATA;
      endcase
    end
    if (burst.size() != 0) begin
      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) due_q.push_back(burst[i]);
    end
  endtask

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    n_errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data  <= stim_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_gap_pct);
  end

  // monitor
  always @(posedge clk) begin : mon
    tcop_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) parse_item(in_data);
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
          n_errors++;
        end else begin
          want = due_q.pop_front();
          if (out_data.kind !== want.kind) report("kind", want.kind, out_data.kind);
          if (out_data.out_byte !== want.out_byte)
            report("out_byte", want.out_byte, out_data.out_byte);
          if (out_data.baud_rate !== want.baud_rate)
            report("baud_rate", want.baud_rate, out_data.baud_rate);
          if (out_data.dtr_out !== want.dtr_out)
            report("dtr_out", want.dtr_out, out_data.dtr_out);
          if (out_data.rts_out !== want.rts_out)
            report("rts_out", want.rts_out, out_data.rts_out);
          if (out_data.last !== want.last) report("last", want.last, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  task automatic add(logic req, logic [7:0] b);
    tcop_pkg::in_t it;
    it.req_type = req;
    it.in_byte  = b;
    stim_q.push_back(it);
    n_items++;
  endtask

  task automatic add_sub_byte(logic [7:0] b);
    add(1'b0, b);
    if (b == tcop_pkg::B_IAC) add(1'b0, tcop_pkg::B_IAC);
  endtask

  task automatic add_comport_sub();
    logic [7:0] cmd;
    logic [7:0] p;
    logic [7:0] ctl_vals [4] = '{tcop_pkg::CTL_DTR_ON, tcop_pkg::CTL_DTR_OFF,
                                 tcop_pkg::CTL_RTS_ON, tcop_pkg::CTL_RTS_OFF};
    int         n;
    bit         empty_sub;
    bit         zero_baud;
    add(1'b0, tcop_pkg::B_IAC);
    add(1'b0, tcop_pkg::B_SB);
    add(1'b0, ($urandom_range(99) < 85) ? tcop_pkg::OPT_COM : 8'($urandom));
    case ($urandom_range(7)) inside
      0: cmd = tcop_pkg::CMD_BAUD;
      1: cmd = tcop_pkg::CMD_DATASIZE;
      2: cmd = tcop_pkg::CMD_PARITY;
      3: cmd = tcop_pkg::CMD_STOPSIZE;
      4, 5: cmd = tcop_pkg::CMD_CONTROL;
      6: cmd = tcop_pkg::CMD_PURGE;
      default: cmd = 8'($urandom);
    endcase
    if ($urandom_range(99) < 5) n = $urandom_range(45, 28);
    else if (cmd == tcop_pkg::CMD_BAUD) n = ($urandom_range(3) == 0) ? $urandom_range(5) : 4;
    else n = $urandom_range(2);
    empty_sub = ($urandom_range(19) == 0);
    zero_baud = (cmd == tcop_pkg::CMD_BAUD) && ($urandom_range(6) == 0);
    if (!empty_sub) begin
      add_sub_byte(cmd);
      for (int i = 0; i < n; i++) begin
        if (cmd == tcop_pkg::CMD_CONTROL && $urandom_range(3) != 0)
          p = ctl_vals[$urandom_range(3)];
        else if (zero_baud) p = 8'd0;
        else p = 8'($urandom);
        add_sub_byte(p);
      end
    end
    add(1'b0, tcop_pkg::B_IAC);
    add(1'b0, tcop_pkg::B_SE);
  endtask

  task automatic add_random_seq();
    int r;
    r = $urandom_range(99);
    if (r < 25) begin
      repeat ($urandom_range(4, 1)) add(1'b0, 8'($urandom_range(254)));
    end else if (r < 30) begin
      add(1'b0, tcop_pkg::B_IAC);
      add(1'b0, tcop_pkg::B_IAC);
    end else if (r < 45) begin
      add(1'b0, tcop_pkg::B_IAC);
      case ($urandom_range(3))
        0: add(1'b0, tcop_pkg::B_WILL);
        1: add(1'b0, tcop_pkg::B_WONT);
        2: add(1'b0, tcop_pkg::B_DO);
        default: add(1'b0, tcop_pkg::B_DONT);
      endcase
      add(1'b0, ($urandom_range(1) == 0) ? tcop_pkg::OPT_COM : 8'($urandom));
    end else if (r < 80) begin
      add_comport_sub();
    end else if (r < 85) begin
      add(1'b1, 8'($urandom));
    end else if (r < 90) begin
      add(1'b0, tcop_pkg::B_IAC);
      add(1'b0, 8'($urandom));
    end else if (r < 95) begin
      // subnegotiation cut short by a stray command
      add(1'b0, tcop_pkg::B_IAC);
      add(1'b0, tcop_pkg::B_SB);
      add(1'b0, tcop_pkg::OPT_COM);
      repeat ($urandom_range(3)) add(1'b0, 8'($urandom_range(254)));
      add(1'b0, tcop_pkg::B_IAC);
      add(1'b0, ($urandom_range(1) == 0) ? 8'($urandom_range(239)) : 8'($urandom_range(254, 241)));
    end else begin
      repeat ($urandom_range(3, 1)) add(1'b0, 8'($urandom));
    end
  endtask

  task automatic drain();
    while (stim_q.size() != 0 || in_valid) @(negedge clk);
    while (due_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int target);
    @(negedge clk);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    while (n_items < target) add_random_seq();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_gap_pct = 20;
    recv_gap_pct = 88;
    add(1'b1, 8'hFF);
    add(1'b0, 8'h00);
    add(1'b0, tcop_pkg::B_IAC); add(1'b0, tcop_pkg::B_IAC);
    add(1'b0, tcop_pkg::B_IAC); add(1'b0, tcop_pkg::B_WILL); add(1'b0, tcop_pkg::OPT_COM);
    add(1'b0, tcop_pkg::B_IAC); add(1'b0, tcop_pkg::B_DO); add(1'b0, 8'h00);
    // unknown command after iac
    add(1'b0, tcop_pkg::B_IAC); add(1'b0, 8'h64);
    // control without parameter
    add(1'b0, tcop_pkg::B_IAC); add(1'b0, tcop_pkg::B_SB);
    add(1'b0, tcop_pkg::OPT_COM); add(1'b0, tcop_pkg::CMD_CONTROL);
    add(1'b0, tcop_pkg::B_IAC); add(1'b0, tcop_pkg::B_SE);
    // purge with an escaped 255 parameter
    add(1'b0, tcop_pkg::B_IAC); add(1'b0, tcop_pkg::B_SB);
    add(1'b0, tcop_pkg::OPT_COM); add(1'b0, tcop_pkg::CMD_PURGE);
    add(1'b0, tcop_pkg::B_IAC); add(1'b0, tcop_pkg::B_IAC);
    add(1'b0, tcop_pkg::B_IAC); add(1'b0, tcop_pkg::B_SE);
    drain();
    run_phase(20, 88, 90);
    run_phase(88, 20, 155);
    run_phase(0, 0, 220);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && due_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
sv/tcop_pkg.sv
sv/tcop_front.sv
sv/tcop_queue.sv
sv/tcop_back.sv
sv/telnet_comport_option_parser_unit.sv
bench/tb.sv
